/* rtl/rexv_pkg.sv */
// ----------------------------------------------------------------------------
// Random excursion variant counter package
// Shared widths, word types and the state numbering of the counting cells.
// ----------------------------------------------------------------------------
package rexv_pkg;

    localparam int STATE_LIMIT = 9;
    localparam int COUNT_WIDTH = 24;
    localparam int NUM_STATES  = 2 * STATE_LIMIT;
    localparam int IDX_W       = $clog2(NUM_STATES);
    localparam int WALK_W      = COUNT_WIDTH + 1;
    localparam int STATE_W     = 5;
    localparam int MINCYC_W    = 24;

    localparam logic [MINCYC_W-1:0]    MINCYC_RESET = MINCYC_W'(500);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic bit_value;
        logic final_bit;
    } in_word_t;

    typedef struct packed {
        logic signed [STATE_W-1:0] state_value;
        logic [COUNT_WIDTH-1:0]    visit_count;
        logic [COUNT_WIDTH-1:0]    cycle_count;
        logic                      too_few_cycles;
        logic                      last_of_run;
    } out_word_t;

    typedef struct packed {
        logic step;
        logic load;
        logic shift;
    } rexv_cell_ctrl_t;

    function automatic logic signed [STATE_W-1:0] state_of(input logic [IDX_W-1:0] idx);
        logic signed [STATE_W:0] s;
        if (int'(idx) < STATE_LIMIT)
        begin
            s = (STATE_W+1)'(int'(idx) - STATE_LIMIT);
        end
        else
        begin
            s = (STATE_W+1)'(int'(idx) - STATE_LIMIT + 1);
        end
        return s[STATE_W-1:0];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
    endfunction

endpackage

/* rtl/rexv_cell.sv */
// ----------------------------------------------------------------------------
// Random excursion variant counting cell
// Holds the visit count of one walk state and one stage of the readout chain.
// ----------------------------------------------------------------------------
module rexv_cell
    import rexv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rexv_cell_ctrl_t        ctrl,
    input  logic                   hit,
    input  logic [COUNT_WIDTH-1:0] rd_in,
    output logic [COUNT_WIDTH-1:0] rd_out
);

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [COUNT_WIDTH-1:0] cnt_upd;
    logic [COUNT_WIDTH-1:0] rd_reg;
    logic [COUNT_WIDTH-1:0] rd_next;

    always_comb
    begin
        cnt_upd = (ctrl.step && hit) ? sat_inc(cnt_reg) : cnt_reg;
        cnt_next = ctrl.load ? '0 : cnt_upd;
        if (ctrl.load)
        begin
            rd_next = cnt_upd;
        end
        else if (ctrl.shift)
        begin
            rd_next = rd_in;
        end
        else
        begin
            rd_next = rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
    end

    assign rd_out = rd_reg;

endmodule

/* rtl/random_excursion_variant_counter.sv */
// ----------------------------------------------------------------------------
// Random excursion variant counter
// Counts walk cycles and visits to each state of a +1/-1 random walk.
// ----------------------------------------------------------------------------
// One sequence bit enters per input word, handshaken by in_valid and in_stall.
// A bit is taken every cycle unless stalled; each one moves the walk sum and
// bumps at most one counter cell in the same cycle. A word with final_bit set
// closes the run: the counts are copied into the readout chain and the counters
// start over at zero, so the next run can begin in the very next cycle.
// The readout gives 18 output words, states -9 to 9 without 0, starting in the
// cycle after the final bit and shifting one word out per cycle along the
// cell chain. A new final bit is stalled only while a readout is still going.
// When out_stall is high the current output word holds and the chain stops.
// The min_cycles register is written through cfg_we and cfg_data; the user
// must write it only while idle, the block does not enforce this. Reset clears
// the walk and the counters and stops the readout; min_cycles returns to 500.
// ----------------------------------------------------------------------------
module random_excursion_variant_counter
    import rexv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_word_t            in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output out_word_t           out_word,
    input  logic                cfg_we,
    input  logic [MINCYC_W-1:0] cfg_data
);

    localparam logic signed [WALK_W-1:0] WALK_MAX = {1'b0, {COUNT_WIDTH{1'b1}}};
    localparam logic signed [WALK_W-1:0] WALK_MIN = {1'b1, {COUNT_WIDTH{1'b0}}};
    localparam logic [IDX_W-1:0]         IDX_LAST = IDX_W'(NUM_STATES - 1);

    logic signed [WALK_W-1:0] walk_reg;
    logic signed [WALK_W-1:0] walk_next;
    logic [COUNT_WIDTH-1:0]   zr_reg;
    logic [COUNT_WIDTH-1:0]   zr_next;
    logic [COUNT_WIDTH-1:0]   zr_upd;
    logic [MINCYC_W-1:0]      min_cycles_reg;
    logic                     busy_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [COUNT_WIDTH-1:0]   cyc_reg;
    logic                     few_reg;
    logic                     in_acc;
    logic                     out_acc;
    logic                     load;
    rexv_cell_ctrl_t          ctrl;
    logic [NUM_STATES-1:0]    hit;
    logic [COUNT_WIDTH-1:0]   chain [NUM_STATES+1];

    assign in_stall = busy_reg && in_word.final_bit;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = busy_reg && !out_stall;
    assign load     = in_acc && in_word.final_bit;

    always_comb
    begin
        if (in_word.bit_value)
        begin
            walk_next = (walk_reg == WALK_MAX) ? walk_reg : walk_reg + WALK_W'(1);
        end
        else
        begin
            walk_next = (walk_reg == WALK_MIN) ? walk_reg : walk_reg - WALK_W'(1);
        end
        // On the last bit J gains one either way: a return to zero or the closing rule.
        zr_upd = (walk_next == '0 || in_word.final_bit) ? sat_inc(zr_reg) : zr_reg;
        zr_next = zr_reg;
        if (in_acc)
        begin
            zr_next = load ? '0 : zr_upd;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_STATES; k++)
        begin : g_cell
            assign hit[k] = (walk_next == WALK_W'(state_of(IDX_W'(k))));

            rexv_cell u_cell
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .hit    (hit[k]),
                .rd_in  (chain[k+1]),
                .rd_out (chain[k])
            );
        end
    endgenerate

    assign chain[NUM_STATES] = '0;

    always_comb
    begin
        ctrl.step  = in_acc;
        ctrl.load  = load;
        ctrl.shift = out_acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= '0;
            zr_reg         <= '0;
            min_cycles_reg <= MINCYC_RESET;
            busy_reg       <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_cycles_reg <= cfg_data;
            end
            if (in_acc)
            begin
                walk_reg <= load ? '0 : walk_next;
            end
            zr_reg <= zr_next;
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (out_acc)
            begin
                if (idx_reg == IDX_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cyc_reg <= zr_upd;
            few_reg <= (zr_upd < min_cycles_reg);
        end
    end

    assign out_valid = busy_reg;

    always_comb
    begin
        out_word.state_value    = state_of(idx_reg);
        out_word.visit_count    = chain[0];
        out_word.cycle_count    = cyc_reg;
        out_word.too_few_cycles = few_reg;
        out_word.last_of_run    = (idx_reg == IDX_LAST);
    end

endmodule

/* verif/random_excursion_variant_counter_tb.sv */
// ----------------------------------------------------------------------------
// Random excursion variant counter testbench
// Drives sequences of walk bits into the counter and holds a running model of
// the walk, the zero-return count and the per-state visit counts. Every output
// word is checked field by field against the oldest predicted word. Both
// channels idle at random. One phase holds the output back long enough that
// the input is stalled. The min_cycles register is written between phases.
// ----------------------------------------------------------------------------
module random_excursion_variant_counter_tb;
    import rexv_pkg::*;

    class excursion_scoreboard;
        logic signed [WALK_W-1:0] walk;
        logic [COUNT_WIDTH-1:0]   returns;
        logic [COUNT_WIDTH-1:0]   visits [NUM_STATES];
        logic [MINCYC_W-1:0]      min_cycles;
        out_word_t                readout_q [$];
        int                       errors;

        function new();
            clear_run();
            min_cycles = MINCYC_RESET;
            errors = 0;
        endfunction

        function void clear_run();
            walk = '0;
            returns = '0;
            foreach (visits[k])
            begin
                visits[k] = '0;
            end
        endfunction

        function logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
            return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
        endfunction

        function void set_min_cycles(input logic [MINCYC_W-1:0] v);
            min_cycles = v;
        endfunction

        function int pending();
            return readout_q.size();
        endfunction

        // Applies one accepted input word and queues the readout of a closed run.
        function void note_input(input in_word_t w);
            int        sum;
            int        s;
            out_word_t o;
            if (w.bit_value)
            begin
                if (walk != {1'b0, {(WALK_W-1){1'b1}}})
                begin
                    walk = walk + 1'b1;
                end
            end
            else
            begin
                if (walk != {1'b1, {(WALK_W-1){1'b0}}})
                begin
                    walk = walk - 1'b1;
                end
            end
            sum = walk;
            if (sum == 0)
            begin
                returns = bump(returns);
            end
            else if (sum >= -STATE_LIMIT && sum < 0)
            begin
                visits[sum + STATE_LIMIT] = bump(visits[sum + STATE_LIMIT]);
            end
            else if (sum > 0 && sum <= STATE_LIMIT)
            begin
                visits[sum + STATE_LIMIT - 1] = bump(visits[sum + STATE_LIMIT - 1]);
            end
            if (w.final_bit)
            begin
                if (sum != 0)
                begin
                    returns = bump(returns);
                end
                for (int k = 0; k < NUM_STATES; k++)
                begin
                    s = (k < STATE_LIMIT) ? k - STATE_LIMIT : k - STATE_LIMIT + 1;
                    o.state_value    = STATE_W'(s);
                    o.visit_count    = visits[k];
                    o.cycle_count    = returns;
                    o.too_few_cycles = (returns < min_cycles);
                    o.last_of_run    = (k == NUM_STATES - 1);
                    readout_q.push_back(o);
                end
                clear_run();
            end
        endfunction

        function void compare_field(input string name, input longint want, input longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(input out_word_t got);
            out_word_t want;
            if (readout_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output word, expected none, actual %h", $time, got);
                return;
            end
            want = readout_q.pop_front();
            compare_field("state_value", want.state_value, got.state_value);
            compare_field("visit_count", want.visit_count, got.visit_count);
            compare_field("cycle_count", want.cycle_count, got.cycle_count);
            compare_field("too_few_cycles", want.too_few_cycles, got.too_few_cycles);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_word_t            in_word;
    logic                out_valid;
    logic                out_stall;
    out_word_t           out_word;
    logic                cfg_we;
    logic [MINCYC_W-1:0] cfg_data;

    excursion_scoreboard sb = new();
    bit                  quiet = 1'b0;
    bit                  hold_req = 1'b0;
    int                  bits_sent = 0;

    random_excursion_variant_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_word(input logic bit_value, input logic final_bit);
        in_word_t w;
        int       gap;
        w.bit_value = bit_value;
        w.final_bit = final_bit;
        if (!quiet && $urandom_range(0, 99) < 3)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_input(w);
        bits_sent++;
    endtask

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_word(1'($urandom_range(0, 1)), i == len - 1);
        end
    endtask

    task automatic send_random_runs(input int budget, input int max_len);
        int stop_at;
        stop_at = bits_sent + budget;
        while (bits_sent < stop_at)
        begin
            send_run($urandom_range(1, max_len));
        end
    endtask

    task automatic write_min_cycles(input logic [MINCYC_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_min_cycles(v);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(out_word);
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = 200;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 7);
            end
        end
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walks that run past the outermost states in both directions, single-bit
        // runs that end away from zero, and a run that ends back at zero.
        for (int i = 0; i < 10; i++)
        begin
            send_word(1'b1, i == 9);
        end
        for (int i = 0; i < 10; i++)
        begin
            send_word(1'b0, i == 9);
        end
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);

        write_min_cycles('0);
        send_random_runs(50, 30);

        write_min_cycles({MINCYC_W{1'b1}});
        send_random_runs(40, 30);

        // The receiver holds off while short runs keep arriving.
        write_min_cycles(MINCYC_W'($urandom_range(0, 8)));
        hold_req = 1'b1;
        send_random_runs(40, 3);

        write_min_cycles(MINCYC_W'($urandom_range(0, 8)));
        quiet = 1'b1;
        send_random_runs(50, 25);
        quiet = 1'b0;

        write_min_cycles(MINCYC_W'($urandom_range(0, 16777215)));
        send_random_runs(20, 20);

        write_min_cycles(MINCYC_W'($urandom_range(0, 6)));
        send_random_runs(50, 20);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
